### design/ntg_pkg.sv
// shared types, constants and constant tables of the note tone generator
// no dependencies
package ntg_pkg;

    localparam int AUDIO_RATE_HZ     = 22050;
    localparam int PHASE_BITS        = 24;
    localparam int SINE_TABLE_DEPTH  = 1024;
    localparam int DECAY_TABLE_DEPTH = 256;
    localparam int SINE_ADDR_BITS    = $clog2(SINE_TABLE_DEPTH);
    localparam int DECAY_ADDR_BITS   = $clog2(DECAY_TABLE_DEPTH);

    // duration to sample count: ms * 22050 / 1000 = ((ms * 441) >> 2) / 5
    localparam logic [8:0]  RATE_MUL    = 9'd441;
    localparam logic [23:0] RECIP_FIVE  = 24'd13421772;   // floor(2^26 / 5)
    localparam int          RECIP_SHIFT = 26;

    // attack ramp saturates from this sample index on
    localparam logic [20:0] ATTACK_END  = 21'd177;
    localparam logic [15:0] UNITY_Q15   = 16'h8000;
    localparam logic [21:0] REL_SCALE   = 22'd3276800;

    typedef enum logic [1:0] {
        SHAPE_SINE      = 2'd0,
        SHAPE_TRI       = 2'd1,
        SHAPE_PULSE     = 2'd2,
        SHAPE_PULSE_ALT = 2'd3
    } wave_t;

    typedef enum logic [0:0] {
        REG_WAVEFORM = 1'b0,
        REG_VOLUME   = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        KIND_START = 1'b0,
        KIND_TICK  = 1'b1
    } kind_t;

    typedef struct packed {
        logic        kind;
        logic [6:0]  midi_note;
        logic [15:0] duration_ms;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               note_end;
    } out_word_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_ATK_DEC,
        MUL_REL,
        MUL_OSC,
        MUL_VOL
    } mul_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_DIV_DEC,
        S_DEC,
        S_DIV_REL,
        S_MUL_ATK,
        S_MUL_REL,
        S_MUL_OSC,
        S_MUL_VOL,
        S_WRITE
    } state_t;

    typedef struct packed {
        logic    start_load;
        logic    start_finish;
        logic    tick_begin;
        logic    div_step;
        logic    dec_load;
        mul_op_t mul_op;
        logic    write;
    } ntg_cmd_t;

    typedef struct packed {
        logic active;
        logic rest;
        logic rel_needed;
        logic out_busy;
    } ntg_status_t;

    typedef logic [15:0] sine_tab_t  [0:256];
    typedef logic [15:0] decay_tab_t [0:DECAY_TABLE_DEPTH-1];
    typedef logic [15:0] atk_tab_t   [0:255];
    typedef logic [PHASE_BITS-1:0] step_tab_t [0:127];

    localparam longint unsigned Q30_ONE = 64'd1073741824;

    // shift and subtract quotient, used only while building the tables
    function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int bit_i = 63; bit_i >= 0; bit_i--) begin
            r = {r[62:0], a[bit_i]};
            if (r >= b) begin
                r = r - b;
                q[bit_i] = 1'b1;
            end
        end
        return q;
    endfunction

    // sin(a), a in [0, pi/2], Q30 series
    function automatic longint unsigned sin_q30(longint unsigned a);
        longint unsigned s;
        longint unsigned t;
        longint unsigned dv;
        s = a;
        t = a;
        for (int n = 1; n < 20; n++) begin
            if (t != 0) begin
                t = (((t * a) >> 30) * a) >> 30;
                dv = longint'(2 * n) * longint'(2 * n + 1);
                t = udiv64(t, dv);
                if ((n & 1) != 0) s = s - t;
                else s = s + t;
            end
        end
        return s;
    endfunction

    // exp(-x), x in [0, 4], Q30 series then four squarings
    function automatic longint unsigned exp_neg_q30(longint unsigned x);
        longint unsigned y;
        longint unsigned s;
        longint unsigned t;
        y = x >> 4;
        s = Q30_ONE;
        t = Q30_ONE;
        for (int n = 1; n < 20; n++) begin
            if (t != 0) begin
                t = udiv64((t * y) >> 30, longint'(n));
                if ((n & 1) != 0) s = s - t;
                else s = s + t;
            end
        end
        for (int k = 0; k < 4; k++) s = (s * s) >> 30;
        return s;
    endfunction

    // quarter wave of the sine, entries 0 to a quarter cycle inclusive
    function automatic sine_tab_t build_sine();
        sine_tab_t       tab;
        longint unsigned v;
        for (int j = 0; j <= 256; j++) begin
            v = (sin_q30((longint'(4 * j) * 64'd1686629713) >> SINE_ADDR_BITS)
                 + 64'd16384) >> 15;
            tab[j] = v[15:0];
        end
        return tab;
    endfunction

    function automatic decay_tab_t build_decay();
        decay_tab_t      tab;
        longint unsigned x;
        longint unsigned e;
        longint unsigned d;
        for (int k = 0; k < DECAY_TABLE_DEPTH; k++) begin
            x = longint'(k) << (32 - DECAY_ADDR_BITS);
            e = exp_neg_q30(x);
            d = 64'd483183821 + ((e * 64'd590558003) >> 30);
            d = (d + 64'd16384) >> 15;
            tab[k] = d[15:0];
        end
        return tab;
    endfunction

    function automatic atk_tab_t build_attack();
        atk_tab_t        tab;
        longint unsigned a;
        for (int i = 0; i < 256; i++) begin
            a = udiv64(longint'(i) * 64'd125 * 64'd32768, longint'(AUDIO_RATE_HZ));
            if (a > 64'd32768) a = 64'd32768;
            tab[i] = a[15:0];
        end
        return tab;
    endfunction

    // note m = 12 * octave + semitone
    function automatic step_tab_t build_step();
        step_tab_t       tab;
        longint unsigned base [0:11];
        longint unsigned num;
        longint unsigned den;
        longint unsigned st;
        int              m;
        base = '{64'd535809, 64'd567670, 64'd601425, 64'd637188, 64'd675077, 64'd715219,
                 64'd757749, 64'd802807, 64'd850544, 64'd901120, 64'd954703, 64'd1011473};
        den = longint'(AUDIO_RATE_HZ) << 16;
        for (int q = 0; q < 11; q++) begin
            for (int r = 0; r < 12; r++) begin
                m = 12 * q + r;
                if (m < 128) begin
                    st = 0;
                    if (m != 0) begin
                        num = (base[r] << q) << PHASE_BITS;
                        st  = udiv64(num + (den >> 1), den);
                    end
                    tab[m] = st[PHASE_BITS-1:0];
                end
            end
        end
        return tab;
    endfunction

    localparam sine_tab_t  SINE_TAB   = build_sine();
    localparam decay_tab_t DECAY_TAB  = build_decay();
    localparam atk_tab_t   ATTACK_TAB = build_attack();
    localparam step_tab_t  STEP_TAB   = build_step();

endpackage

### design/ntg_ctrl.sv
// sequencer of the note tone generator: accepts words, steps the datapath
// depends on ntg_pkg
module ntg_ctrl
    import ntg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_kind,
    input  ntg_status_t status,
    output logic        in_stall,
    output ntg_cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.mul_op = MUL_NONE;
        in_stall   = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_kind == KIND_START)
                    begin
                        cmd.start_load = 1'b1;
                        state_next     = S_START;
                    end
                    else if (status.active && !status.rest)
                    begin
                        cmd.tick_begin = 1'b1;
                        cnt_next       = 4'd7;
                        state_next     = S_DIV_DEC;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_START:
            begin
                cmd.start_finish = 1'b1;
                state_next       = S_IDLE;
            end
            S_DIV_DEC:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0) state_next = S_DEC;
            end
            S_DEC:
            begin
                cmd.dec_load = 1'b1;
                cnt_next     = 4'd15;
                state_next   = status.rel_needed ? S_DIV_REL : S_MUL_ATK;
            end
            S_DIV_REL:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0) state_next = S_MUL_ATK;
            end
            S_MUL_ATK:
            begin
                cmd.mul_op = MUL_ATK_DEC;
                state_next = S_MUL_REL;
            end
            S_MUL_REL:
            begin
                cmd.mul_op = MUL_REL;
                state_next = S_MUL_OSC;
            end
            S_MUL_OSC:
            begin
                cmd.mul_op = MUL_OSC;
                state_next = S_MUL_VOL;
            end
            S_MUL_VOL:
            begin
                cmd.mul_op = MUL_VOL;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (!status.out_busy)
                begin
                    cmd.write  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### design/ntg_datapath.sv
// note state, oscillator, shared divider, shared multiplier and output register
// depends on ntg_pkg
module ntg_datapath
    import ntg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [14:0] cfg_data,
    input  in_word_t    in_word,
    input  ntg_cmd_t    cmd,
    output ntg_status_t status,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_word
);

    logic [1:0]            waveform_reg;
    logic [14:0]           volume_reg;
    logic [PHASE_BITS-1:0] phase_acc_reg, phase_step_reg;
    logic [20:0]           idx_reg, total_reg;
    logic                  active_reg, rest_reg;
    logic [22:0]           scaled_reg;
    logic [6:0]            note_reg;
    logic                  rel_needed_reg;
    logic [15:0]           atk_reg, dec_reg;
    logic [16:0]           osc_mag_reg;
    logic                  osc_neg_reg;
    logic [24:0]           rem_reg, den_reg;
    logic [15:0]           num_reg, quo_reg;
    logic [46:0]           prod_reg;
    logic                  out_valid_reg;
    out_word_t             out_word_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg <= SHAPE_SINE;
            volume_reg   <= 15'd5000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WAVEFORM: waveform_reg <= cfg_data[1:0];
                REG_VOLUME:   volume_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    // sample count from duration
    logic [24:0] ms_prod;
    logic [48:0] recip_prod;
    logic [22:0] cnt_q, cnt_r;
    logic [20:0] cnt_fix;
    assign ms_prod    = in_word.duration_ms * RATE_MUL;
    assign recip_prod = scaled_reg * RECIP_FIVE;
    assign cnt_q      = recip_prod[RECIP_SHIFT +: 23];
    assign cnt_r      = scaled_reg - (cnt_q * 23'd5);
    assign cnt_fix    = (cnt_r >= 23'd5) ? (cnt_q[20:0] + 21'd1) : cnt_q[20:0];

    // oscillator
    logic [9:0]         sine_k;
    logic [8:0]         sine_j;
    logic [14:0]        tri_p;
    logic signed [16:0] tri_d;
    logic [16:0]        tri_v;
    logic [16:0]        osc_mag;
    logic               osc_neg;
    assign sine_k = phase_acc_reg[PHASE_BITS-1 -: 10];
    assign sine_j = sine_k[8] ? (9'd256 - {1'b0, sine_k[7:0]}) : {1'b0, sine_k[7:0]};
    assign tri_p  = phase_acc_reg[PHASE_BITS-1 -: 15];
    assign tri_d  = $signed({2'b00, tri_p}) - 17'sd16384;
    assign tri_v  = (tri_d < 0) ? 17'(-tri_d) << 2 : 17'(tri_d) << 2;

    always_comb
    begin
        case (waveform_reg)
            SHAPE_SINE:
            begin
                osc_mag = {1'b0, SINE_TAB[sine_j]};
                osc_neg = sine_k[9];
            end
            SHAPE_TRI:
            begin
                osc_neg = (tri_v < 17'd32768);
                osc_mag = osc_neg ? (17'd32768 - tri_v) : (tri_v - 17'd32768);
            end
            default:
            begin
                osc_mag = 17'd32768;
                osc_neg = tri_p[14];
            end
        endcase
    end

    // divider operands
    logic [27:0] idx_x100, tot_x88;
    logic [42:0] rel_num;
    logic [25:0] div_trial;
    logic        div_fit;
    assign idx_x100  = idx_reg * 7'd100;
    assign tot_x88   = total_reg * 7'd88;
    assign rel_num   = (total_reg - idx_reg) * REL_SCALE;
    assign div_trial = {rem_reg, num_reg[15]};
    assign div_fit   = (div_trial >= {1'b0, den_reg});

    // multiplier operand select
    logic [30:0] mul_a;
    logic [15:0] mul_b;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            MUL_ATK_DEC:
            begin
                mul_a = {15'd0, atk_reg};
                mul_b = dec_reg;
            end
            MUL_REL:
            begin
                mul_a = prod_reg[45:15];
                mul_b = rel_needed_reg ? quo_reg : UNITY_Q15;
            end
            MUL_OSC:
            begin
                mul_a = {14'd0, osc_mag_reg};
                mul_b = prod_reg[30:15];
            end
            MUL_VOL:
            begin
                mul_a = prod_reg[30:0];
                mul_b = {1'b0, volume_reg};
            end
            default: ;
        endcase
    end

    // note state and output control
    logic [20:0] idx_inc;
    logic        last_sample;
    assign idx_inc     = idx_reg + 21'd1;
    assign last_sample = (idx_inc >= total_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg  <= '0;
            phase_step_reg <= '0;
            idx_reg        <= '0;
            total_reg      <= '0;
            active_reg     <= 1'b0;
            rest_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.write) out_valid_reg <= 1'b1;
            else if (!out_stall) out_valid_reg <= 1'b0;
            if (cmd.start_finish)
            begin
                total_reg      <= cnt_fix;
                idx_reg        <= '0;
                phase_acc_reg  <= '0;
                phase_step_reg <= STEP_TAB[note_reg];
                rest_reg       <= (note_reg == 7'd0);
                active_reg     <= (cnt_fix != 21'd0);
            end
            if (cmd.tick_begin) phase_acc_reg <= phase_acc_reg + phase_step_reg;
            if (cmd.write)
            begin
                if (active_reg)
                begin
                    idx_reg <= idx_inc;
                    if (last_sample) active_reg <= 1'b0;
                end
            end
        end
    end

    // payload registers
    logic [16:0] mag;
    assign mag = prod_reg[46:30];

    always_ff @(posedge clk)
    begin
        if (cmd.start_load)
        begin
            scaled_reg <= ms_prod[24:2];
            note_reg   <= in_word.midi_note;
        end
        if (cmd.tick_begin)
        begin
            osc_mag_reg    <= osc_mag;
            osc_neg_reg    <= osc_neg;
            atk_reg        <= (idx_reg < ATTACK_END) ? ATTACK_TAB[idx_reg[7:0]] : UNITY_Q15;
            rel_needed_reg <= (idx_x100 > tot_x88);
            rem_reg        <= {4'd0, idx_reg};
            num_reg        <= '0;
            den_reg        <= {4'd0, total_reg};
            quo_reg        <= '0;
        end
        if (cmd.dec_load)
        begin
            dec_reg <= DECAY_TAB[quo_reg[7:0]];
            rem_reg <= rel_num[40:16];
            num_reg <= rel_num[15:0];
            den_reg <= ({4'd0, total_reg} << 3) + ({4'd0, total_reg} << 2);
            quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_fit ? 25'(div_trial - {1'b0, den_reg}) : div_trial[24:0];
            quo_reg <= {quo_reg[14:0], div_fit};
            num_reg <= {num_reg[14:0], 1'b0};
        end
        if (cmd.mul_op != MUL_NONE) prod_reg <= mul_a * mul_b;
        if (cmd.write)
        begin
            if (active_reg && !rest_reg)
                out_word_reg.sample <= osc_neg_reg ? -$signed(mag[15:0]) : $signed(mag[15:0]);
            else
                out_word_reg.sample <= '0;
            out_word_reg.note_end <= active_reg && last_sample;
        end
    end

    assign status.active     = active_reg;
    assign status.rest       = rest_reg;
    assign status.rel_needed = rel_needed_reg;
    assign status.out_busy   = out_valid_reg && out_stall;
    assign out_valid         = out_valid_reg;
    assign out_word          = out_word_reg;

endmodule

### design/note_tone_generator_with_envelope.sv
// top level of the note tone generator: controller plus datapath
// depends on ntg_pkg, ntg_ctrl, ntg_datapath
//
// A start word (kind 0) loads a midi note (0 is a rest) and a duration in ms
// and gives no result. A tick word (kind 1) gives one sample word. During a
// sounding note a tick runs the accept, the shared restoring divider for the
// decay table index, a table lookup, then, once the release phase (final 12
// percent) is reached, the divider again for the release gain, then four
// passes through the single shared multiplier and a write. Ticks while idle
// or during a rest go straight from the accept to the write. While the
// previous result still waits stalled, the write waits too. The output word
// sits in a register, so a new word is taken while the last result still
// waits.
// Configuration writes (waveform, volume) take effect at once.
module note_tone_generator_with_envelope
    import ntg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_word,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_word,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [14:0] cfg_data
);

    ntg_cmd_t    cmd;
    ntg_status_t status;

    // sequencer
    ntg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_kind  (in_word.kind),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // arithmetic and note state
    ntg_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

### design/ntg_checker.sv
// port-level checks of the note tone generator, bound to the top level
// depends on ntg_pkg and note_tone_generator_with_envelope
module ntg_checker
    import ntg_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input in_word_t   in_word,
    input logic       out_valid,
    input logic       out_stall,
    input out_word_t  out_word
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    // a start word never produces a result
    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_word.kind == KIND_START && !out_valid |=> !out_valid)
        else $error("start word produced a result");

    // block is busy right after any accepted word
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("word accepted back to back");

    // a new result only appears after the block was working
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared from idle");

endmodule

bind note_tone_generator_with_envelope ntg_checker u_chk (.*);
